[rtl/core/quadrant_conv3x3_defines.svh]
// Assertion macros for the quadrant 3x3 convolution block.
// Expects clk and rst_n in the scope of each use.
`ifndef QUADRANT_CONV3X3_DEFINES_SVH
`define QUADRANT_CONV3X3_DEFINES_SVH

// same-cycle implication, disabled during reset
`define QC3_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled during reset
`define QC3_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/core/qc3_pkg.sv]
// Shared constants, types and kernel functions of the quadrant 3x3 convolution.
// No dependencies; every other file but the defines header refers to it by scoped names.
package qc3_pkg;

  localparam int MAX_SIDE    = 32;
  localparam int SAMPLE_BITS = 16;
  localparam int MAX_HALF    = MAX_SIDE / 2;
  localparam int COORD_W     = $clog2(MAX_SIDE);
  localparam int STEP_W      = COORD_W + 1;
  localparam int VALUE_W     = 20;
  localparam int KSEL_W      = 2;
  localparam int HALF_W      = 5;
  localparam int SLOTS       = 3;
  localparam int SLOT_W      = 2;
  localparam int WORD_W      = SLOTS * SAMPLE_BITS;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 8;

  localparam logic [CFG_IDX_W-1:0] REG_KERNEL_SELECT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HALF_SIZE     = 2'd1;

  localparam logic [KSEL_W-1:0] KSEL_IDENTITY  = 2'd0;
  localparam logic [KSEL_W-1:0] KSEL_PATTERN_A = 2'd1;
  localparam logic [KSEL_W-1:0] KSEL_PATTERN_B = 2'd2;

  localparam logic [1:0] COEF_ZERO = 2'd0;
  localparam logic [1:0] COEF_POS  = 2'd1;
  localparam logic [1:0] COEF_NEG  = 2'd2;

  localparam logic [SLOT_W-1:0] SLOT_0 = 2'd0;
  localparam logic [SLOT_W-1:0] SLOT_1 = 2'd1;
  localparam logic [SLOT_W-1:0] SLOT_2 = 2'd2;

  typedef logic signed [SAMPLE_BITS-1:0] sample_t;
  typedef logic [WORD_W-1:0] word_t;

  typedef struct packed {
    logic                   en;
    logic [COORD_W-1:0]     addr;
    logic [SLOT_W-1:0]      slot;
    sample_t                data;
  } mem_wr_t;

  typedef struct packed {
    logic                   start;
    logic [COORD_W-1:0]     orow;
    logic [SLOT_W-1:0]      mid_slot;
    logic                   two_rows;
  } emit_start_t;

  typedef struct packed {
    logic                   busy;
    logic [STEP_W-1:0]      ptr;
    logic [SLOTS-1:0]       slot_used;
  } emit_status_t;

  function automatic logic [SLOT_W-1:0] slot_inc(input logic [SLOT_W-1:0] s);
    logic [SLOT_W-1:0] r;
    case (s)
      SLOT_0:  r = SLOT_1;
      SLOT_1:  r = SLOT_2;
      default: r = SLOT_0;
    endcase
    return r;
  endfunction

  function automatic logic [SLOT_W-1:0] slot_dec(input logic [SLOT_W-1:0] s);
    logic [SLOT_W-1:0] r;
    case (s)
      SLOT_1:  r = SLOT_0;
      SLOT_2:  r = SLOT_1;
      default: r = SLOT_2;
    endcase
    return r;
  endfunction

  function automatic sample_t lane_of(input word_t w, input logic [SLOT_W-1:0] s);
    sample_t r;
    case (s)
      SLOT_1:  r = w[SAMPLE_BITS +: SAMPLE_BITS];
      SLOT_2:  r = w[2*SAMPLE_BITS +: SAMPLE_BITS];
      default: r = w[0 +: SAMPLE_BITS];
    endcase
    return r;
  endfunction

  // kernel table entry [kr][kc], unflipped
  function automatic logic [1:0] kernel_coef(input logic [KSEL_W-1:0] ksel,
                                             input logic [1:0] kr,
                                             input logic [1:0] kc);
    logic [3:0] idx;
    logic [1:0] r;
    idx = {1'b0, kr, 1'b0} + {2'b00, kr} + {2'b00, kc};
    r = COEF_ZERO;
    case (ksel)
      KSEL_IDENTITY: begin
        r = (idx == 4'd4) ? COEF_POS : COEF_ZERO;
      end
      KSEL_PATTERN_A: begin
        case (idx)
          4'd2, 4'd3, 4'd5: r = COEF_NEG;
          default:          r = COEF_POS;
        endcase
      end
      KSEL_PATTERN_B: begin
        case (idx)
          4'd1, 4'd6, 4'd7: r = COEF_POS;
          4'd2, 4'd3, 4'd5: r = COEF_NEG;
          default:          r = COEF_ZERO;
        endcase
      end
      default: r = COEF_ZERO;
    endcase
    return r;
  endfunction

endpackage

[rtl/core/qc3_ifs.sv]
// Stream and configuration channel interfaces of the quadrant 3x3 convolution.
// Depends on qc3_pkg for field widths.
interface qc3_in_if;
  logic                      valid;
  logic                      ready;
  logic signed [qc3_pkg::SAMPLE_BITS-1:0] pixel;
  logic                      frame_start;
  modport source (output valid, pixel, frame_start, input ready);
  modport sink   (input valid, pixel, frame_start, output ready);
endinterface

interface qc3_out_if;
  logic                      valid;
  logic                      ready;
  logic signed [qc3_pkg::VALUE_W-1:0] value;
  logic [qc3_pkg::COORD_W-1:0] row;
  logic [qc3_pkg::COORD_W-1:0] col;
  logic                      run_last;
  logic                      frame_last;
  modport source (output valid, value, row, col, run_last, frame_last, input ready);
  modport sink   (input valid, value, row, col, run_last, frame_last, output ready);
endinterface

interface qc3_cfg_if;
  logic                      valid;
  logic                      ready;
  logic [qc3_pkg::CFG_IDX_W-1:0]  index;
  logic [qc3_pkg::CFG_DATA_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

[rtl/core/qc3_line_mem.sv]
// Line buffer memory: one word per column, one sample lane per row slot.
// Lane write enable, registered read data. Depends on qc3_pkg.
module qc3_line_mem (
  input  logic                          clk,
  input  qc3_pkg::mem_wr_t              wr,
  input  logic                          rd_en,
  input  logic [qc3_pkg::COORD_W-1:0]   rd_addr,
  output qc3_pkg::word_t                rd_data
);

  qc3_pkg::word_t mem_r [qc3_pkg::MAX_SIDE];
  qc3_pkg::word_t rd_data_r;

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem_r[wr.addr][wr.slot * qc3_pkg::SAMPLE_BITS +: qc3_pkg::SAMPLE_BITS] <= wr.data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

[rtl/core/qc3_in_ctrl.sv]
// Input side: raster position, line buffer writes, row-end emission requests
// and the interlock against the running emission. Depends on qc3_pkg, qc3_ifs.
module qc3_in_ctrl (
  input  logic                          clk,
  input  logic                          rst_n,
  qc3_in_if.sink                        in_ch,
  input  logic [qc3_pkg::COORD_W-1:0]   h,
  input  qc3_pkg::emit_status_t         status,
  output qc3_pkg::mem_wr_t              wr,
  output qc3_pkg::emit_start_t          start
);

  logic [qc3_pkg::COORD_W-1:0] row_r, row_nxt;
  logic [qc3_pkg::COORD_W-1:0] col_r, col_nxt;
  logic [qc3_pkg::SLOT_W-1:0]  slot_r, slot_nxt;

  logic [qc3_pkg::COORD_W:0]   side;
  logic [qc3_pkg::COORD_W:0]   side_m1_w;
  logic [qc3_pkg::COORD_W-1:0] side_m1;
  logic [qc3_pkg::COORD_W-1:0] h_m1;
  logic                        restart;
  logic [qc3_pkg::COORD_W-1:0] eff_row, eff_col, lr;
  logic [qc3_pkg::SLOT_W-1:0]  eff_slot;
  logic                        row_end, emit_a, emit_b;
  logic                        hit, stall, accept;
  logic [qc3_pkg::COORD_W:0]   row_inc;

  assign side      = {h, 1'b0};
  assign side_m1_w = side - (qc3_pkg::COORD_W+1)'(1);
  assign side_m1   = side_m1_w[qc3_pkg::COORD_W-1:0];
  assign h_m1      = h - qc3_pkg::COORD_W'(1);

  assign restart  = in_ch.frame_start || ({1'b0, row_r} >= side) || ({1'b0, col_r} >= side);
  assign eff_row  = restart ? '0 : row_r;
  assign eff_col  = restart ? '0 : col_r;
  assign eff_slot = restart ? qc3_pkg::SLOT_0 : slot_r;

  assign row_end = (eff_col == side_m1);
  assign lr      = (eff_row < h) ? eff_row : eff_row - h;
  assign emit_a  = (lr != '0);
  assign emit_b  = (lr == h_m1);

  // hold writes that would land on a column the emission has not yet read, and row-ending pixels while it runs
  assign hit    = status.slot_used[eff_slot] && ({1'b0, eff_col} >= status.ptr);
  assign stall  = status.busy && (row_end || hit);
  assign accept = in_ch.valid && !stall;

  assign in_ch.ready = !stall;

  assign wr.en   = accept;
  assign wr.addr = eff_col;
  assign wr.slot = eff_slot;
  assign wr.data = in_ch.pixel;

  assign start.start    = accept && row_end && (emit_a || emit_b);
  assign start.orow     = emit_a ? eff_row - qc3_pkg::COORD_W'(1) : eff_row;
  assign start.mid_slot = emit_a ? qc3_pkg::slot_dec(eff_slot) : eff_slot;
  assign start.two_rows = emit_a && emit_b;

  assign row_inc = {1'b0, eff_row} + (qc3_pkg::COORD_W+1)'(1);

  always_comb begin
    row_nxt  = row_r;
    col_nxt  = col_r;
    slot_nxt = slot_r;
    if (accept) begin
      if (row_end) begin
        col_nxt = '0;
        if (row_inc >= side) begin
          row_nxt  = '0;
          slot_nxt = qc3_pkg::SLOT_0;
        end else begin
          row_nxt  = row_inc[qc3_pkg::COORD_W-1:0];
          slot_nxt = qc3_pkg::slot_inc(eff_slot);
        end
      end else begin
        col_nxt  = eff_col + qc3_pkg::COORD_W'(1);
        row_nxt  = eff_row;
        slot_nxt = eff_slot;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_r  <= '0;
      col_r  <= '0;
      slot_r <= qc3_pkg::SLOT_0;
    end else begin
      row_r  <= row_nxt;
      col_r  <= col_nxt;
      slot_r <= slot_nxt;
    end
  end

endmodule

[rtl/core/qc3_emit.sv]
// Emission sequencer: sweeps the line buffer column by column, keeps a
// three-column window, sums the masked 3x3 taps and drives the result register.
// Depends on qc3_pkg, qc3_ifs.
module qc3_emit (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic [qc3_pkg::COORD_W-1:0]   h,
  input  logic [qc3_pkg::KSEL_W-1:0]    ksel,
  input  qc3_pkg::emit_start_t          start,
  input  qc3_pkg::word_t                rd_data,
  output logic                          rd_en,
  output logic [qc3_pkg::COORD_W-1:0]   rd_addr,
  output qc3_pkg::emit_status_t         status,
  qc3_out_if.source                     out_ch
);

  logic                          busy_r, busy_nxt;
  logic [qc3_pkg::STEP_W-1:0]    step_r, step_nxt;
  logic [qc3_pkg::COORD_W-1:0]   orow_r, orow_nxt;
  logic [qc3_pkg::SLOT_W-1:0]    mid_r, mid_nxt;
  logic                          second_r, second_nxt;
  qc3_pkg::word_t                win0_r, win1_r;

  logic                          out_valid_r;
  logic signed [qc3_pkg::VALUE_W-1:0] value_r;
  logic [qc3_pkg::COORD_W-1:0]   row_r, col_r;
  logic                          run_last_r, frame_last_r;

  logic [qc3_pkg::STEP_W-1:0]    side, side_p1, c_w;
  logic [qc3_pkg::COORD_W-1:0]   side_m1, c, ct, ct_end, bt, bt_end;
  logic                          advance, out_step, last_step;
  logic [2:0]                    rv, cv;
  logic [qc3_pkg::SLOT_W-1:0]    top_slot, bot_slot;
  logic [qc3_pkg::SLOT_W-1:0]    rs [3];
  qc3_pkg::word_t                cw [3];
  logic signed [qc3_pkg::VALUE_W-1:0] acc;

  assign side     = {h, 1'b0};
  assign side_p1  = side + qc3_pkg::STEP_W'(1);
  assign side_m1  = h + h - qc3_pkg::COORD_W'(1);
  assign c_w      = step_r - qc3_pkg::STEP_W'(2);
  assign c        = c_w[qc3_pkg::COORD_W-1:0];

  assign advance   = busy_r && (!out_valid_r || out_ch.ready);
  assign out_step  = (step_r >= qc3_pkg::STEP_W'(2));
  assign last_step = (step_r == side_p1);

  assign rd_en   = advance && (step_r < side);
  assign rd_addr = step_r[qc3_pkg::COORD_W-1:0];

  assign bt     = (orow_r < h) ? '0 : h;
  assign bt_end = bt + h - qc3_pkg::COORD_W'(1);
  assign ct     = (c < h) ? '0 : h;
  assign ct_end = ct + h - qc3_pkg::COORD_W'(1);

  assign rv = {orow_r != bt_end, 1'b1, orow_r != bt};
  assign cv = {c != ct_end, 1'b1, c != ct};

  assign top_slot = qc3_pkg::slot_dec(mid_r);
  assign bot_slot = qc3_pkg::slot_inc(mid_r);
  assign rs[0] = top_slot;
  assign rs[1] = mid_r;
  assign rs[2] = bot_slot;
  assign cw[0] = win0_r;
  assign cw[1] = win1_r;
  assign cw[2] = rd_data;

  always_comb begin
    qc3_pkg::sample_t s;
    logic signed [qc3_pkg::VALUE_W-1:0] ext;
    logic [1:0] coef;
    acc = '0;
    for (int kr = 0; kr < 3; kr++) begin
      for (int kc = 0; kc < 3; kc++) begin
        s    = qc3_pkg::lane_of(cw[kc], rs[kr]);
        ext  = {{(qc3_pkg::VALUE_W-qc3_pkg::SAMPLE_BITS){s[qc3_pkg::SAMPLE_BITS-1]}}, s};
        coef = qc3_pkg::kernel_coef(ksel, 2'(2 - kr), 2'(2 - kc));
        if (rv[kr] && cv[kc]) begin
          case (coef)
            qc3_pkg::COEF_POS: acc = acc + ext;
            qc3_pkg::COEF_NEG: acc = acc - ext;
            default:           acc = acc;
          endcase
        end
      end
    end
  end

  always_comb begin
    status.busy      = busy_r;
    status.ptr       = step_r;
    status.slot_used = '0;
    status.slot_used[mid_r]    = 1'b1;
    status.slot_used[top_slot] = rv[0];
    status.slot_used[bot_slot] = rv[2];
  end

  always_comb begin
    busy_nxt   = busy_r;
    step_nxt   = step_r;
    orow_nxt   = orow_r;
    mid_nxt    = mid_r;
    second_nxt = second_r;
    if (start.start) begin
      busy_nxt   = 1'b1;
      step_nxt   = '0;
      orow_nxt   = start.orow;
      mid_nxt    = start.mid_slot;
      second_nxt = start.two_rows;
    end else if (advance) begin
      if (last_step) begin
        step_nxt = '0;
        if (second_r) begin
          orow_nxt   = orow_r + qc3_pkg::COORD_W'(1);
          mid_nxt    = bot_slot;
          second_nxt = 1'b0;
        end else begin
          busy_nxt = 1'b0;
        end
      end else begin
        step_nxt = step_r + qc3_pkg::STEP_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r   <= 1'b0;
      step_r   <= '0;
      second_r <= 1'b0;
    end else begin
      busy_r   <= busy_nxt;
      step_r   <= step_nxt;
      second_r <= second_nxt;
    end
  end

  always_ff @(posedge clk) begin
    orow_r <= orow_nxt;
    mid_r  <= mid_nxt;
    if (advance) begin
      win0_r <= win1_r;
      win1_r <= rd_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance && out_step) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && out_step) begin
      value_r      <= acc;
      row_r        <= orow_r;
      col_r        <= c;
      run_last_r   <= (c == side_m1) && !second_r;
      frame_last_r <= (c == side_m1) && (orow_r == side_m1);
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.value      = value_r;
  assign out_ch.row        = row_r;
  assign out_ch.col        = col_r;
  assign out_ch.run_last   = run_last_r;
  assign out_ch.frame_last = frame_last_r;

endmodule

[rtl/core/quadrant_conv3x3.sv]
// Top level of the quadrant 3x3 convolution: configuration registers, input
// control, line buffer memory and emission. Depends on qc3_pkg, qc3_ifs, defines.
//
//   channel  dir  handshake      payload
//   in_ch    in   valid/ready    pixel, frame_start
//   out_ch   out  valid/ready    value, row, col, run_last, frame_last
//   cfg_ch   in   valid/ready    index, data (always ready)
//
// A pixel is written into the line buffer in the cycle it transfers; pixels
// keep streaming while an output row drains, as long as they land on columns
// already read. Each output row of side S sweeps the single memory read port,
// one column per cycle while results are taken; a row-ending pixel waits
// until the running emission is done and transfers the cycle after.
// Reset clears position, configuration and the busy, step and output valid
// state of the sequencer; the line buffer is not cleared.
// A stalled result holds the sweep and the read port in place.
`include "quadrant_conv3x3_defines.svh"

module quadrant_conv3x3 (
  input  logic       clk,
  input  logic       rst_n,
  qc3_in_if.sink     in_ch,
  qc3_out_if.source  out_ch,
  qc3_cfg_if.sink    cfg_ch
);

  logic [qc3_pkg::KSEL_W-1:0]  ksel_r, ksel_nxt;
  logic [qc3_pkg::HALF_W-1:0]  half_r, half_nxt;
  logic [qc3_pkg::COORD_W-1:0] h_eff;

  qc3_pkg::mem_wr_t            wr;
  qc3_pkg::emit_start_t        start;
  qc3_pkg::emit_status_t       status;
  qc3_pkg::word_t              rd_data;
  logic                        rd_en;
  logic [qc3_pkg::COORD_W-1:0] rd_addr;
  logic                        wr_col_read;

  assign cfg_ch.ready = 1'b1;

  always_comb begin
    ksel_nxt = ksel_r;
    half_nxt = half_r;
    if (cfg_ch.valid) begin
      case (cfg_ch.index)
        qc3_pkg::REG_KERNEL_SELECT: ksel_nxt = cfg_ch.data[qc3_pkg::KSEL_W-1:0];
        qc3_pkg::REG_HALF_SIZE:     half_nxt = cfg_ch.data[qc3_pkg::HALF_W-1:0];
        default:                    ksel_nxt = ksel_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ksel_r <= qc3_pkg::KSEL_IDENTITY;
      half_r <= qc3_pkg::HALF_W'(qc3_pkg::MAX_HALF);
    end else begin
      ksel_r <= ksel_nxt;
      half_r <= half_nxt;
    end
  end

  always_comb begin
    if (half_r == '0) begin
      h_eff = qc3_pkg::COORD_W'(1);
    end else if (half_r > qc3_pkg::HALF_W'(qc3_pkg::MAX_HALF)) begin
      h_eff = qc3_pkg::COORD_W'(qc3_pkg::MAX_HALF);
    end else begin
      h_eff = qc3_pkg::COORD_W'(half_r);
    end
  end

  qc3_in_ctrl u_in_ctrl (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .h      (h_eff),
    .status (status),
    .wr     (wr),
    .start  (start)
  );

  qc3_line_mem u_line_mem (
    .clk     (clk),
    .wr      (wr),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  qc3_emit u_emit (
    .clk     (clk),
    .rst_n   (rst_n),
    .h       (h_eff),
    .ksel    (ksel_r),
    .start   (start),
    .rd_data (rd_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .status  (status),
    .out_ch  (out_ch)
  );

  assign wr_col_read = ({1'b0, wr.addr} < status.ptr);

  `QC3_ASSERT_SAME(a_start_idle, start.start, !status.busy, "emission started while busy")
  `QC3_ASSERT_NEXT(a_start_busy, start.start, status.busy, "emission did not start")
  `QC3_ASSERT_SAME(a_wr_safe, wr.en && status.busy && status.slot_used[wr.slot], wr_col_read, "write clobbers unread column")
  `QC3_ASSERT_SAME(a_frame_run, out_ch.valid && out_ch.frame_last, out_ch.run_last, "frame end without run end")

endmodule
